// File: rtl/ebsb_pkg.sv
// shared types and constants for the balanced box split block
package ebsb_pkg;

  localparam int CNT_W   = 16;
  localparam int IDX_W   = 16;
  localparam int OUT_W   = 32;
  localparam int TOT_W   = 33;
  localparam int PROD_W  = 32;
  localparam int RIDX_W  = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int NSTAGE  = 16;

  localparam logic [RIDX_W-1:0] REG_COUNT = 3'd0;
  localparam logic [RIDX_W-1:0] REG_LO_X  = 3'd1;
  localparam logic [RIDX_W-1:0] REG_HI_X  = 3'd2;
  localparam logic [RIDX_W-1:0] REG_LO_Y  = 3'd3;
  localparam logic [RIDX_W-1:0] REG_HI_Y  = 3'd4;
  localparam logic [RIDX_W-1:0] REG_LO_Z  = 3'd5;
  localparam logic [RIDX_W-1:0] REG_HI_Z  = 3'd6;

  typedef struct packed {
    logic                      busy;
    logic [CNT_W-1:0]          cnt;
    logic [TOT_W-1:0]          base;
    logic [CNT_W-1:0]          rem;
    logic [1:0]                sd;
    logic                      box_empty;
    logic                      whole;
    logic [2:0][OUT_W-1:0]     lo;
    logic [2:0][OUT_W-1:0]     hi;
  } cfg_t;

  typedef struct packed {
    logic              oor;
    logic [TOT_W-1:0]  prod_b;
    logic [PROD_W-1:0] prod_r;
  } item_t;

  typedef struct packed {
    logic              oor;
    logic [TOT_W-1:0]  prod_b;
    logic [PROD_W-1:0] part;
    logic [IDX_W-1:0]  quo;
  } div_t;

endpackage

// File: rtl/equal_block_subspace_bounds_top.sv
// throughput: one word per cycle unless out_ready stalls the output or setup is busy;
// the 16-stage quotient pipeline takes a new word each cycle that it advances
// after reset or a register write, in_ready stays low while the
// 33-step serial divider forms the base piece size and remainder
// reset is synchronous active high and clears valid flags, queue and setup registers
module equal_block_subspace_bounds_top #(
  parameter int DIMS       = 3,
  parameter int COORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ebsb_pkg::RIDX_W-1:0] cfg_index,
  input  logic [ebsb_pkg::OUT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ebsb_pkg::IDX_W-1:0]  piece_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_lo_x,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_hi_x,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_lo_y,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_hi_y,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_lo_z,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_hi_z,
  output logic                        piece_empty,
  output logic                        index_out_of_range
);

  localparam int CW = (COORD_BITS < ebsb_pkg::OUT_W) ? COORD_BITS : ebsb_pkg::OUT_W;

  ebsb_pkg::cfg_t  cfg;
  logic            q_valid;
  ebsb_pkg::item_t q_item;
  logic            q_pop;

  ebsb_setup #(.DIMS(DIMS), .CW(CW)) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ebsb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .piece_index (piece_index),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  ebsb_back #(.DIMS(DIMS)) u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .piece_lo_x         (piece_lo_x),
    .piece_hi_x         (piece_hi_x),
    .piece_lo_y         (piece_lo_y),
    .piece_hi_y         (piece_hi_y),
    .piece_lo_z         (piece_lo_z),
    .piece_hi_z         (piece_hi_z),
    .piece_empty        (piece_empty),
    .index_out_of_range (index_out_of_range)
  );

endmodule

// File: rtl/ebsb_setup.sv
// configuration registers and per-setup split divider
module ebsb_setup #(
  parameter int DIMS = 3,
  parameter int CW   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ebsb_pkg::RIDX_W-1:0]   cfg_index,
  input  logic [ebsb_pkg::OUT_W-1:0]    cfg_data,
  output ebsb_pkg::cfg_t                cfg
);

  localparam int SH = ebsb_pkg::OUT_W - CW;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]                   state;
  logic [ebsb_pkg::CNT_W-1:0]   cnt;
  logic [5:0][ebsb_pkg::OUT_W-1:0] box;
  logic [ebsb_pkg::TOT_W-1:0]   dvd;
  logic [ebsb_pkg::CNT_W-1:0]   r;
  logic [5:0]                   stp;
  logic [1:0]                   sd;
  logic                         box_empty;

  logic [2:0][ebsb_pkg::OUT_W-1:0] lo_c;
  logic [2:0][ebsb_pkg::OUT_W-1:0] hi_c;
  logic [ebsb_pkg::TOT_W-1:0]   tot;
  logic [1:0]                   sd_next;
  logic                         empty_next;
  logic [33:0]                  ext;
  logic [ebsb_pkg::CNT_W:0]     t;
  logic                         qbit;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      lo_c[d] = ebsb_pkg::OUT_W'($signed(box[2*d] << SH) >>> SH);
      hi_c[d] = ebsb_pkg::OUT_W'($signed(box[2*d+1] << SH) >>> SH);
    end
  end

  always_comb begin
    tot = '0;
    sd_next = 2'd0;
    empty_next = 1'b0;
    ext = '0;
    for (int d = 0; d < 3; d++) begin
      if (d < DIMS) begin
        ext = {{2{hi_c[d][ebsb_pkg::OUT_W-1]}}, hi_c[d]}
            - {{2{lo_c[d][ebsb_pkg::OUT_W-1]}}, lo_c[d]} + 34'd1;
        if ($signed(lo_c[d]) > $signed(hi_c[d])) begin
          empty_next = 1'b1;
        end
        if (d == 0 || ext[ebsb_pkg::TOT_W-1:0] > tot) begin
          tot = ext[ebsb_pkg::TOT_W-1:0];
          sd_next = 2'(d);
        end
      end
    end
  end

  assign t    = {r, dvd[ebsb_pkg::TOT_W-1]};
  assign qbit = (t >= {1'b0, cnt});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= ebsb_pkg::CNT_W'(1);
      box   <= '0;
    end else if (cfg_we) begin
      state <= ST_LOAD;
      case (cfg_index)
        ebsb_pkg::REG_COUNT: cnt    <= cfg_data[ebsb_pkg::CNT_W-1:0];
        ebsb_pkg::REG_LO_X:  box[0] <= cfg_data;
        ebsb_pkg::REG_HI_X:  box[1] <= cfg_data;
        ebsb_pkg::REG_LO_Y:  box[2] <= cfg_data;
        ebsb_pkg::REG_HI_Y:  box[3] <= cfg_data;
        ebsb_pkg::REG_LO_Z:  box[4] <= cfg_data;
        ebsb_pkg::REG_HI_Z:  box[5] <= cfg_data;
        default: ;
      endcase
    end else begin
      case (state)
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (stp == 6'(ebsb_pkg::TOT_W - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      dvd       <= tot;
      r         <= '0;
      stp       <= '0;
      sd        <= sd_next;
      box_empty <= empty_next;
    end else if (state == ST_DIV) begin
      dvd <= {dvd[ebsb_pkg::TOT_W-2:0], qbit};
      r   <= qbit ? ebsb_pkg::CNT_W'(t - {1'b0, cnt}) : t[ebsb_pkg::CNT_W-1:0];
      stp <= stp + 6'd1;
    end
  end

  always_comb begin
    cfg.busy      = (state != ST_IDLE);
    cfg.cnt       = cnt;
    cfg.base      = dvd;
    cfg.rem       = r;
    cfg.sd        = sd;
    cfg.box_empty = box_empty;
    cfg.whole     = box_empty || (cnt == ebsb_pkg::CNT_W'(1));
    cfg.lo        = lo_c;
    cfg.hi        = hi_c;
  end

`ifndef SYNTHESIS
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (state == ST_LOAD))
    else $error("setup not restarted after write");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (stp < 6'(ebsb_pkg::TOT_W)))
    else $error("divider step overrun");
`endif

endmodule

// File: rtl/ebsb_front.sv
// word intake, range check, products and queue toward the back end
module ebsb_front (
  input  logic                        clk,
  input  logic                        rst,
  input  ebsb_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ebsb_pkg::IDX_W-1:0]  piece_index,
  output logic                        q_valid,
  output ebsb_pkg::item_t             q_item,
  input  logic                        q_pop
);

  ebsb_pkg::item_t mem [ebsb_pkg::QDEPTH];
  logic [ebsb_pkg::QPTR_W-1:0] wp;
  logic [ebsb_pkg::QPTR_W-1:0] rp;
  logic [ebsb_pkg::QPTR_W:0]   count;
  logic                        push;
  ebsb_pkg::item_t             item;
  logic [48:0]                 pb;

  assign in_ready = !cfg.busy && (count != (ebsb_pkg::QPTR_W+1)'(ebsb_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign pb       = piece_index * cfg.base;

  always_comb begin
    item.oor    = ({1'b0, piece_index} >= {1'b0, cfg.cnt});
    item.prod_b = pb[ebsb_pkg::TOT_W-1:0];
    item.prod_r = piece_index * cfg.rem;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (q_pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (ebsb_pkg::QPTR_W+1)'(push) - (ebsb_pkg::QPTR_W+1)'(q_pop);
    end
  end

  assign q_valid = (count != '0);
  assign q_item  = mem[rp];

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (rst)
    count <= (ebsb_pkg::QPTR_W+1)'(ebsb_pkg::QDEPTH))
    else $error("queue overfilled");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (count != '0))
    else $error("pop from empty queue");
  a_push: assert property (@(posedge clk) disable iff (rst)
    push |-> !cfg.busy)
    else $error("word taken during setup");
`endif

endmodule

// File: rtl/ebsb_back.sv
// divider pipeline and bound assembly
module ebsb_back #(
  parameter int DIMS = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ebsb_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  ebsb_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_lo_x,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_hi_x,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_lo_y,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_hi_y,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_lo_z,
  output logic [ebsb_pkg::OUT_W-1:0]  piece_hi_z,
  output logic                        piece_empty,
  output logic                        index_out_of_range
);

  logic adv;
  ebsb_pkg::div_t stg [ebsb_pkg::NSTAGE+1];
  logic [ebsb_pkg::NSTAGE:0] vld;

  logic                       f_vld;
  logic                       f_oor;
  logic                       f_zero;
  logic [ebsb_pkg::TOT_W-1:0] f_start;
  logic [ebsb_pkg::TOT_W-1:0] f_end;

  logic [ebsb_pkg::CNT_W:0]   rsum;
  logic                       carry;
  logic [ebsb_pkg::TOT_W-1:0] start_c;
  logic [ebsb_pkg::TOT_W-1:0] end_c;
  logic [2:0][ebsb_pkg::OUT_W-1:0] lo_o;
  logic [2:0][ebsb_pkg::OUT_W-1:0] hi_o;
  logic [2:0][ebsb_pkg::OUT_W-1:0] lo_r;
  logic [2:0][ebsb_pkg::OUT_W-1:0] hi_r;
  logic                       empty_o;

  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].oor    <= q_item.oor;
      stg[0].prod_b <= q_item.prod_b;
      stg[0].part   <= q_item.prod_r;
      stg[0].quo    <= '0;
    end
  end

  for (genvar j = 0; j < ebsb_pkg::NSTAGE; j++) begin : g_div
    localparam int K = ebsb_pkg::NSTAGE - 1 - j;
    logic [ebsb_pkg::PROD_W-1:0] dsh;
    logic                        ge;
    assign dsh = ebsb_pkg::PROD_W'(cfg.cnt) << K;
    assign ge  = (stg[j].part >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[j+1].oor    <= stg[j].oor;
        stg[j+1].prod_b <= stg[j].prod_b;
        stg[j+1].part   <= ge ? stg[j].part - dsh : stg[j].part;
        stg[j+1].quo    <= stg[j].quo | (ebsb_pkg::IDX_W'(ge) << K);
      end
    end
  end

  assign rsum    = {1'b0, stg[ebsb_pkg::NSTAGE].part[ebsb_pkg::CNT_W-1:0]}
                 + {1'b0, cfg.rem};
  assign carry   = (rsum >= {1'b0, cfg.cnt});
  assign start_c = stg[ebsb_pkg::NSTAGE].prod_b
                 + ebsb_pkg::TOT_W'(stg[ebsb_pkg::NSTAGE].quo);
  assign end_c   = start_c + cfg.base + ebsb_pkg::TOT_W'(carry) - ebsb_pkg::TOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= vld[ebsb_pkg::NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_oor   <= stg[ebsb_pkg::NSTAGE].oor;
      f_zero  <= (cfg.base == '0) && !carry;
      f_start <= start_c;
      f_end   <= end_c;
    end
  end

  always_comb begin
    lo_o = '0;
    hi_o = '0;
    for (int d = 0; d < 3; d++) begin
      if (d < DIMS) begin
        if (f_oor || (!cfg.whole && f_zero)) begin
          lo_o[d] = ebsb_pkg::OUT_W'(1);
          hi_o[d] = '0;
        end else if (!cfg.whole && cfg.sd == 2'(d)) begin
          lo_o[d] = cfg.lo[d] + f_start[ebsb_pkg::OUT_W-1:0];
          hi_o[d] = cfg.lo[d] + f_end[ebsb_pkg::OUT_W-1:0];
        end else begin
          lo_o[d] = cfg.lo[d];
          hi_o[d] = cfg.hi[d];
        end
      end
    end
    if (f_oor) begin
      empty_o = 1'b1;
    end else if (cfg.whole) begin
      empty_o = cfg.box_empty;
    end else begin
      empty_o = f_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r               <= lo_o;
      hi_r               <= hi_o;
      piece_empty        <= empty_o;
      index_out_of_range <= f_oor;
    end
  end

  assign piece_lo_x = lo_r[0];
  assign piece_hi_x = hi_r[0];
  assign piece_lo_y = lo_r[1];
  assign piece_hi_y = hi_r[1];
  assign piece_lo_z = lo_r[2];
  assign piece_hi_z = hi_r[2];

endmodule
